@@ sv/ksl_pkg.sv @@
// Shared types and constants for the keyed sequential list unit.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package ksl_pkg;

  localparam int KEY_LOW_W  = 64;
  localparam int KEY_MID_W  = 64;
  localparam int KEY_HIGH_W = 32;
  localparam int AMOUNT_W   = 32;
  localparam int COST_W     = 32;
  localparam int POS_W      = 4;
  localparam int ENTRIES_W  = 5;
  localparam int CMD_W      = 2;

  typedef logic [CMD_W-1:0] op_t;

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_REMOVE = 2'd1;
  localparam op_t OP_READ   = 2'd2;

  typedef struct packed {
    logic [KEY_LOW_W-1:0]  key_low;
    logic [KEY_MID_W-1:0]  key_mid;
    logic [KEY_HIGH_W-1:0] key_high;
    logic [AMOUNT_W-1:0]   amount;
    logic [COST_W-1:0]     cost;
  } entry_t;

  typedef enum logic [1:0] {
    RD_POS  = 2'd0,
    RD_IDX  = 2'd1,
    RD_NEXT = 2'd2
  } rd_src_t;

  typedef enum logic {
    WR_APPEND = 1'b0,
    WR_SHIFT  = 1'b1
  } wr_src_t;

  typedef struct packed {
    logic    load_item;
    logic    rd_en;
    rd_src_t rd_src;
    logic    wr_en;
    wr_src_t wr_src;
    logic    idx_clr;
    logic    idx_inc;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    set_ok;
    logic    res_load;
  } ctrl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic cnt_zero;
    logic cnt_full;
    logic pos_ok;
    logic key_hit;
    logic idx_last;
    logic shift_last;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

@@ sv/ksl_ctrl.sv @@
// Controller state machine of the keyed sequential list unit.
// Depends on ksl_pkg; drives ksl_datapath through command and status structs.
`default_nettype none

module ksl_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  ksl_pkg::dp_status_t status,
  output ksl_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE       = 7'b0000001,
    S_DISPATCH   = 7'b0000010,
    S_SEARCH_RD  = 7'b0000100,
    S_SEARCH_CMP = 7'b0001000,
    S_SHIFT_RD   = 7'b0010000,
    S_SHIFT_WR   = 7'b0100000,
    S_FINISH     = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_src = ksl_pkg::RD_POS;
    cmd.wr_src = ksl_pkg::WR_APPEND;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_FINISH;
        case (status.op)
          ksl_pkg::OP_INSERT: begin
            if (!status.cnt_full) begin
              cmd.wr_en   = 1'b1;
              cmd.wr_src  = ksl_pkg::WR_APPEND;
              cmd.cnt_inc = 1'b1;
              cmd.set_ok  = 1'b1;
            end
          end
          ksl_pkg::OP_REMOVE: begin
            if (!status.cnt_zero) begin
              cmd.idx_clr = 1'b1;
              state_next  = S_SEARCH_RD;
            end
          end
          ksl_pkg::OP_READ: begin
            if (status.pos_ok) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_src = ksl_pkg::RD_POS;
              cmd.set_ok = 1'b1;
            end
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_SEARCH_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = ksl_pkg::RD_IDX;
        state_next = S_SEARCH_CMP;
      end
      S_SEARCH_CMP: begin
        priority if (status.key_hit && status.idx_last) begin
          cmd.cnt_dec = 1'b1;
          cmd.set_ok  = 1'b1;
          state_next  = S_FINISH;
        end else if (status.key_hit) begin
          state_next = S_SHIFT_RD;
        end else if (status.idx_last) begin
          state_next = S_FINISH;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SEARCH_RD;
        end
      end
      S_SHIFT_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = ksl_pkg::RD_NEXT;
        state_next = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_src  = ksl_pkg::WR_SHIFT;
        cmd.idx_inc = 1'b1;
        if (status.shift_last) begin
          cmd.cnt_dec = 1'b1;
          cmd.set_ok  = 1'b1;
          state_next  = S_FINISH;
        end else begin
          state_next = S_SHIFT_RD;
        end
      end
      S_FINISH: begin
        if (!status.out_busy) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/ksl_datapath.sv @@
// Datapath of the keyed sequential list unit: item registers, entry memory,
// fill count, scan index and result register. Depends on ksl_pkg.
`default_nettype none

module ksl_datapath #(
  parameter int CAPACITY = 16
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  ksl_pkg::ctrl_cmd_t                    cmd_ctl,
  output ksl_pkg::dp_status_t                   status,
  input  wire  [ksl_pkg::CMD_W-1:0]             cmd,
  input  wire  [ksl_pkg::KEY_LOW_W-1:0]         key_low,
  input  wire  [ksl_pkg::KEY_MID_W-1:0]         key_mid,
  input  wire  [ksl_pkg::KEY_HIGH_W-1:0]        key_high,
  input  wire  signed [ksl_pkg::AMOUNT_W-1:0]   amount,
  input  wire  [ksl_pkg::COST_W-1:0]            cost_bits,
  input  wire  [ksl_pkg::POS_W-1:0]             position,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic                                  success,
  output logic [ksl_pkg::ENTRIES_W-1:0]         entries,
  output logic                                  is_empty,
  output logic                                  is_full,
  output logic [ksl_pkg::KEY_LOW_W-1:0]         found_low,
  output logic [ksl_pkg::KEY_MID_W-1:0]         found_mid,
  output logic [ksl_pkg::KEY_HIGH_W-1:0]        found_high,
  output logic signed [ksl_pkg::AMOUNT_W-1:0]   found_amount,
  output logic [ksl_pkg::COST_W-1:0]            found_cost
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW + 1 > ksl_pkg::POS_W + 1) ? CW + 1 : ksl_pkg::POS_W + 1;

  ksl_pkg::op_t              op;
  ksl_pkg::entry_t           item;
  logic [ksl_pkg::POS_W-1:0] pos;
  logic [AW-1:0]             idx;
  logic [CW-1:0]             count;
  logic                      ok;

  ksl_pkg::entry_t mem [CAPACITY];
  ksl_pkg::entry_t rdata;
  ksl_pkg::entry_t wr_data;
  ksl_pkg::entry_t res_found;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;

  always_ff @(posedge clk) begin
    if (cmd_ctl.load_item) begin
      op            <= cmd;
      item.key_low  <= key_low;
      item.key_mid  <= key_mid;
      item.key_high <= key_high;
      item.amount   <= amount;
      item.cost     <= cost_bits;
      pos           <= position;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ctl.idx_clr) begin
      idx <= '0;
    end else if (cmd_ctl.idx_inc) begin
      idx <= idx + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ok    <= 1'b0;
    end else begin
      if (cmd_ctl.cnt_inc) begin
        count <= count + CW'(1);
      end else if (cmd_ctl.cnt_dec) begin
        count <= count - CW'(1);
      end
      if (cmd_ctl.load_item) begin
        ok <= 1'b0;
      end else if (cmd_ctl.set_ok) begin
        ok <= 1'b1;
      end
    end
  end

  always_comb begin
    case (cmd_ctl.rd_src)
      ksl_pkg::RD_POS:  rd_addr = AW'(pos);
      ksl_pkg::RD_IDX:  rd_addr = idx;
      ksl_pkg::RD_NEXT: rd_addr = idx + AW'(1);
      default:          rd_addr = idx;
    endcase
  end

  always_comb begin
    unique case (cmd_ctl.wr_src)
      ksl_pkg::WR_APPEND: begin
        wr_addr = AW'(count);
        wr_data = item;
      end
      ksl_pkg::WR_SHIFT: begin
        wr_addr = idx;
        wr_data = rdata;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_ctl.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  assign status.op         = op;
  assign status.cnt_zero   = (count == '0);
  assign status.cnt_full   = (count == CW'(CAPACITY));
  assign status.pos_ok     = (XW'(pos) < XW'(count));
  assign status.key_hit    = (rdata.key_low == item.key_low) &&
                             (rdata.key_mid == item.key_mid) &&
                             (rdata.key_high == item.key_high);
  assign status.idx_last   = ((XW'(idx) + XW'(1)) >= XW'(count));
  assign status.shift_last = ((XW'(idx) + XW'(2)) >= XW'(count));
  assign status.out_busy   = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_ctl.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ctl.res_load) begin
      success   <= ok;
      entries   <= ksl_pkg::ENTRIES_W'(count);
      is_empty  <= (count == '0);
      is_full   <= (count == CW'(CAPACITY));
      res_found <= (ok && (op == ksl_pkg::OP_READ)) ? rdata : '0;
    end
  end

  assign found_low    = res_found.key_low;
  assign found_mid    = res_found.key_mid;
  assign found_high   = res_found.key_high;
  assign found_amount = res_found.amount;
  assign found_cost   = res_found.cost;

endmodule

`default_nettype wire

@@ sv/keyed_sequential_list_unit.sv @@
// Keyed sequential list unit: top level joining controller and datapath.
// Depends on ksl_pkg, ksl_ctrl and ksl_datapath.
//
// Usage: one command transaction on the input channel (in_valid/in_stall)
// gives exactly one result transaction on the output channel
// (out_valid/out_stall). Commands: insert appends an entry, remove deletes
// the first entry with a matching 20-byte key and closes the gap, read
// returns the entry at a position below the count. Every result carries the
// count and the empty and full flags.
// Throughput: a new command is taken only while the unit is idle. Insert,
// read, unused codes and remove on an empty list pass S_DISPATCH and then
// S_FINISH. Remove on a non-empty list also scans the entry memory one
// entry at a time (read, then compare) and compacts it one entry at a time
// (read the next entry, then write it one place down). The result register
// is loaded on leaving S_FINISH, once it is free.
// Reset: count is zero, no result is pending; memory contents are left as
// they are and are never read before being written.
// Receiver stall: the result register holds; the unit still takes the next
// command and waits before loading its result until the register is free.
`default_nettype none

module keyed_sequential_list_unit #(
  parameter int CAPACITY = 16
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  [ksl_pkg::CMD_W-1:0]             cmd,
  input  wire  [ksl_pkg::KEY_LOW_W-1:0]         key_low,
  input  wire  [ksl_pkg::KEY_MID_W-1:0]         key_mid,
  input  wire  [ksl_pkg::KEY_HIGH_W-1:0]        key_high,
  input  wire  signed [ksl_pkg::AMOUNT_W-1:0]   amount,
  input  wire  [ksl_pkg::COST_W-1:0]            cost_bits,
  input  wire  [ksl_pkg::POS_W-1:0]             position,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic                                  success,
  output logic [ksl_pkg::ENTRIES_W-1:0]         entries,
  output logic                                  is_empty,
  output logic                                  is_full,
  output logic [ksl_pkg::KEY_LOW_W-1:0]         found_low,
  output logic [ksl_pkg::KEY_MID_W-1:0]         found_mid,
  output logic [ksl_pkg::KEY_HIGH_W-1:0]        found_high,
  output logic signed [ksl_pkg::AMOUNT_W-1:0]   found_amount,
  output logic [ksl_pkg::COST_W-1:0]            found_cost
);

  ksl_pkg::ctrl_cmd_t  ctl;
  ksl_pkg::dp_status_t status;

  ksl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (ctl)
  );

  ksl_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd_ctl      (ctl),
    .status       (status),
    .cmd          (cmd),
    .key_low      (key_low),
    .key_mid      (key_mid),
    .key_high     (key_high),
    .amount       (amount),
    .cost_bits    (cost_bits),
    .position     (position),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .success      (success),
    .entries      (entries),
    .is_empty     (is_empty),
    .is_full      (is_full),
    .found_low    (found_low),
    .found_mid    (found_mid),
    .found_high   (found_high),
    .found_amount (found_amount),
    .found_cost   (found_cost)
  );

endmodule

`default_nettype wire

@@ tb/list_check_pkg.sv @@
// Result prediction and checking for the keyed sequential list unit testbench.
// Depends on ksl_pkg for the command codes and the entry layout.
package list_check_pkg;
  import ksl_pkg::*;

  localparam int  CAPACITY    = 16;
  localparam op_t OP_UNUSED   = 2'd3;

  typedef struct packed {
    logic [KEY_LOW_W-1:0]  key_low;
    logic [KEY_MID_W-1:0]  key_mid;
    logic [KEY_HIGH_W-1:0] key_high;
  } list_key_t;

  typedef struct packed {
    logic                 success;
    logic [ENTRIES_W-1:0] entries;
    logic                 is_empty;
    logic                 is_full;
    entry_t               found;
  } list_reply_t;

  class list_checker;
    entry_t      stored[CAPACITY];
    int          fill;
    int          errors;
    list_reply_t awaited_replies[$];

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function list_reply_t predict_outcome(op_t op, entry_t item, logic [POS_W-1:0] pos);
      list_reply_t r;
      int          hit;
      r   = '0;
      hit = -1;
      case (op)
        OP_INSERT: begin
          if (fill < CAPACITY) begin
            stored[fill] = item;
            fill++;
            r.success = 1'b1;
          end
        end
        OP_REMOVE: begin
          for (int i = 0; i < fill; i++) begin
            if (hit < 0 && stored[i].key_low == item.key_low &&
                stored[i].key_mid == item.key_mid && stored[i].key_high == item.key_high) begin
              hit = i;
            end
          end
          if (hit >= 0) begin
            for (int i = hit + 1; i < fill; i++) begin
              stored[i-1] = stored[i];
            end
            fill--;
            r.success = 1'b1;
          end
        end
        OP_READ: begin
          if (int'(pos) < fill) begin
            r.found   = stored[pos];
            r.success = 1'b1;
          end
        end
        default: begin
        end
      endcase
      r.entries  = ENTRIES_W'(fill);
      r.is_empty = (fill == 0);
      r.is_full  = (fill == CAPACITY);
      return r;
    endfunction

    function void note_command(op_t op, entry_t item, logic [POS_W-1:0] pos);
      awaited_replies.push_back(predict_outcome(op, item, pos));
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_response(list_reply_t got);
      list_reply_t want;
      if (awaited_replies.size() == 0) begin
        $display("%0t: unexpected result transaction, actual %h", $time, got);
        errors++;
      end else begin
        want = awaited_replies.pop_front();
        compare_field("success", 64'(want.success), 64'(got.success));
        compare_field("entries", 64'(want.entries), 64'(got.entries));
        compare_field("is_empty", 64'(want.is_empty), 64'(got.is_empty));
        compare_field("is_full", 64'(want.is_full), 64'(got.is_full));
        compare_field("found_low", want.found.key_low, got.found.key_low);
        compare_field("found_mid", want.found.key_mid, got.found.key_mid);
        compare_field("found_high", 64'(want.found.key_high), 64'(got.found.key_high));
        compare_field("found_amount", 64'(want.found.amount), 64'(got.found.amount));
        compare_field("found_cost", 64'(want.found.cost), 64'(got.found.cost));
      end
    endfunction
  endclass

endpackage

@@ tb/keyed_sequential_list_unit_test.sv @@
// Testbench top for keyed_sequential_list_unit: directed and random commands
// under several idle and stall mixes. Depends on ksl_pkg and list_check_pkg.
module keyed_sequential_list_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ksl_pkg::*;
  import list_check_pkg::*;

  localparam int POOL_SIZE        = 8;
  localparam int RANDOM_PER_PHASE = 106;
  localparam int DRAIN_CYCLES     = 2 * CAPACITY + 20;
  localparam int LIMIT_CYCLES     = 400000;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      cmd       = '0;
  logic [KEY_LOW_W-1:0]  key_low   = '0;
  logic [KEY_MID_W-1:0]  key_mid   = '0;
  logic [KEY_HIGH_W-1:0] key_high  = '0;
  logic [AMOUNT_W-1:0]   amount    = '0;
  logic [COST_W-1:0]     cost_bits = '0;
  logic [POS_W-1:0]      position  = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  success;
  logic [ENTRIES_W-1:0]  entries;
  logic                  is_empty;
  logic                  is_full;
  logic [KEY_LOW_W-1:0]  found_low;
  logic [KEY_MID_W-1:0]  found_mid;
  logic [KEY_HIGH_W-1:0] found_high;
  logic [AMOUNT_W-1:0]   found_amount;
  logic [COST_W-1:0]     found_cost;

  int unsigned cycle_count   = 0;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  list_key_t   key_pool[POOL_SIZE];
  list_checker sb;

  keyed_sequential_list_unit #(.CAPACITY(CAPACITY)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .key_low(key_low), .key_mid(key_mid), .key_high(key_high),
    .amount(amount), .cost_bits(cost_bits), .position(position),
    .out_valid(out_valid), .out_stall(out_stall),
    .success(success), .entries(entries), .is_empty(is_empty), .is_full(is_full),
    .found_low(found_low), .found_mid(found_mid), .found_high(found_high),
    .found_amount(found_amount), .found_cost(found_cost)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_response(list_reply_t'({success, entries, is_empty, is_full, found_low,
                                       found_mid, found_high, found_amount, found_cost}));
    end
  end

  initial begin
    wait (cycle_count == LIMIT_CYCLES);
    $display("keyed_sequential_list_unit_test: done, errors");
    $finish;
  end

  function automatic list_key_t fresh_key();
    list_key_t k;
    k.key_low  = {$urandom(), $urandom()};
    k.key_mid  = {$urandom(), $urandom()};
    k.key_high = $urandom();
    return k;
  endfunction

  task automatic issue_command(input op_t op, input list_key_t k, input logic [AMOUNT_W-1:0] amt,
                               input logic [COST_W-1:0] cost, input logic [POS_W-1:0] pos);
    entry_t item;
    item = '{key_low: k.key_low, key_mid: k.key_mid, key_high: k.key_high,
             amount: amt, cost: cost};
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    cmd       <= op;
    key_low   <= k.key_low;
    key_mid   <= k.key_mid;
    key_high  <= k.key_high;
    amount    <= amt;
    cost_bits <= cost;
    position  <= pos;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_command(op, item, pos);
  endtask

  task automatic random_command(input int fill_goal);
    int         pick;
    op_t        op;
    list_key_t  k;
    logic [3:0] pos;
    pick = $urandom_range(99);
    if (pick < 2) begin
      op = OP_UNUSED;
    end else if (pick < ((sb.fill < fill_goal) ? 62 : 30)) begin
      op = OP_INSERT;
    end else if (pick < 80) begin
      op = OP_REMOVE;
    end else begin
      op = OP_READ;
    end
    k = key_pool[$urandom_range(POOL_SIZE - 1)];
    if ($urandom_range(4) == 0) begin
      k = fresh_key();
    end
    if (op == OP_REMOVE && sb.fill > 0 && $urandom_range(3) != 0) begin
      pick = $urandom_range(sb.fill - 1);
      k = '{sb.stored[pick].key_low, sb.stored[pick].key_mid, sb.stored[pick].key_high};
    end
    pos = POS_W'($urandom_range(15));
    if (op == OP_READ && sb.fill > 0 && $urandom_range(4) != 0) begin
      pos = POS_W'($urandom_range(sb.fill - 1));
    end
    issue_command(op, k, $urandom(), $urandom(), pos);
  endtask

  initial begin
    int goal;
    sb = new();
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = fresh_key();
    end
    // near misses: differ from the first key in one part only
    key_pool[1] = key_pool[0];
    key_pool[1].key_high[0] = ~key_pool[0].key_high[0];
    key_pool[2] = key_pool[0];
    key_pool[2].key_mid[63] = ~key_pool[0].key_mid[63];
    key_pool[3] = key_pool[0];
    key_pool[3].key_low[31] = ~key_pool[0].key_low[31];
    key_pool[4] = '{64'h0000_0000_6567_6170, '0, '0};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    issue_command(OP_REMOVE, '0, '0, '0, '0);
    issue_command(OP_READ, '0, '0, '0, '0);
    issue_command(OP_UNUSED, '1, '1, '1, 4'd15);
    issue_command(OP_INSERT, '0, 32'h8000_0000, '0, '0);
    issue_command(OP_INSERT, '1, 32'h7fff_ffff, '1, '1);
    issue_command(OP_INSERT, key_pool[0], '1, $urandom(), '0);
    for (int i = 1; i < 4; i++) begin
      issue_command(OP_REMOVE, key_pool[i], $urandom(), $urandom(), POS_W'($urandom()));
    end
    issue_command(OP_READ, '1, '1, '1, 4'd2);
    issue_command(OP_READ, '0, '0, '0, 4'd3);
    while (sb.fill < CAPACITY) begin
      issue_command(OP_INSERT, fresh_key(), $urandom(), $urandom(), POS_W'($urandom()));
    end
    issue_command(OP_INSERT, key_pool[4], $urandom(), $urandom(), '0);
    issue_command(OP_READ, '0, '0, '0, 4'd15);
    issue_command(OP_REMOVE, '1, '0, '0, '0);
    issue_command(OP_READ, '0, '0, '0, 4'd1);
    issue_command(OP_UNUSED, '0, '0, '0, '0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 50; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 50; end
        default: begin send_idle_pct = 19; stall_pct = 19; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        case ((n / 20) % 3)
          0: goal = CAPACITY;
          1: goal = 0;
          default: goal = $urandom_range(CAPACITY);
        endcase
        random_command(goal);
      end
    end

    in_valid <= 1'b0;
    while (sb.awaited_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("keyed_sequential_list_unit_test: done, clean");
    end else begin
      $display("keyed_sequential_list_unit_test: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/ksl_pkg.sv
sv/ksl_ctrl.sv
sv/ksl_datapath.sv
sv/keyed_sequential_list_unit.sv
tb/list_check_pkg.sv
tb/keyed_sequential_list_unit_test.sv
